@@ hdl/rgb_to_hsv_converter_macros.svh @@
// Assertion macros used by the checker file of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rhc_pkg.sv @@
// Package of the RGB to HSV converter: widths, constants, types and the divide step.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

	localparam int CHANNEL_BITS  = 8;
	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
	localparam int SAT_BITS      = 16;
	// quotient bits per divider lane, one pipeline stage each
	localparam int DIV_QW        = (HUE_BITS > SAT_BITS) ? HUE_BITS : SAT_BITS;
	localparam int DIV_W         = CHANNEL_BITS + DIV_QW;
	// signed degrees * spread, and its non-negative form after wrapping
	localparam int DEG_W         = CHANNEL_BITS + 10;
	localparam int DEG_POS_W     = CHANNEL_BITS + 9;

	localparam int SECTOR_DEG    = 60;
	localparam int GREEN_BASE    = 120;
	localparam int BLUE_BASE     = 240;
	localparam int FULL_DEG      = 360;

	typedef logic [CHANNEL_BITS-1:0] rhc_chan_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} rhc_sector_t;

	typedef struct packed {
		logic            en;
		logic            valid;
	} rhc_pipe_ctl_t;

	typedef struct packed {
		logic [DIV_W-1:0] hue_num;
		rhc_chan_t        hue_den;
		logic [DIV_W-1:0] sat_num;
		rhc_chan_t        sat_den;
		rhc_chan_t        bright;
	} rhc_div_word_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		logic [SAT_BITS-1:0] sat;
		rhc_chan_t           bright;
	} rhc_hsv_t;

	// One restoring divide step. w holds {remainder, numerator bits left, quotient bits}.
	// The top CHANNEL_BITS of w stay below d.
	function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
			input rhc_chan_t d);
		logic [CHANNEL_BITS:0] part;
		logic [CHANNEL_BITS:0] rest;
		logic [DIV_W-1:0]      res;
		part = w[DIV_W-1:DIV_QW-1];
		rest = part - {1'b0, d};
		if (part >= {1'b0, d}) begin
			res = {rest[CHANNEL_BITS-1:0], w[DIV_QW-2:0], 1'b1};
		end else begin
			res = {part[CHANNEL_BITS-1:0], w[DIV_QW-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hdl/rhc_ifs.sv @@
// Stream interfaces of the RGB to HSV converter: RGB words in, HSV words out.
`timescale 1ns / 1ps
`default_nettype none

interface rhc_rgb_if import rhc_pkg::*; ();
	logic      valid;
	logic      ready;
	rhc_chan_t red;
	rhc_chan_t green;
	rhc_chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if import rhc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [HUE_BITS-1:0] hue;
	logic [SAT_BITS-1:0] saturation;
	rhc_chan_t           brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

@@ hdl/rhc_div_pipe.sv @@
// Pipelined restoring divider, two lanes (hue, saturation), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_pipe import rhc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  rhc_pipe_ctl_t ctl,
	input  rhc_div_word_t in_word,
	output logic          out_valid,
	output rhc_hsv_t      out_word
);

	logic [DIV_QW-1:0] vld_s;
	logic [DIV_W-1:0]  hue_w_s [DIV_QW];
	rhc_chan_t         hue_d_s [DIV_QW];
	logic [DIV_W-1:0]  sat_w_s [DIV_QW];
	rhc_chan_t         sat_d_s [DIV_QW];
	rhc_chan_t         bright_s [DIV_QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.en) begin
			vld_s <= {vld_s[DIV_QW-2:0], ctl.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			hue_w_s[0]  <= div_step(in_word.hue_num, in_word.hue_den);
			hue_d_s[0]  <= in_word.hue_den;
			sat_w_s[0]  <= div_step(in_word.sat_num, in_word.sat_den);
			sat_d_s[0]  <= in_word.sat_den;
			bright_s[0] <= in_word.bright;
			for (int k = 1; k < DIV_QW; k++) begin
				hue_w_s[k]  <= div_step(hue_w_s[k-1], hue_d_s[k-1]);
				hue_d_s[k]  <= hue_d_s[k-1];
				sat_w_s[k]  <= div_step(sat_w_s[k-1], sat_d_s[k-1]);
				sat_d_s[k]  <= sat_d_s[k-1];
				bright_s[k] <= bright_s[k-1];
			end
		end
	end

	// quotient sits in the low bits after the last step
	assign out_valid       = vld_s[DIV_QW-1];
	assign out_word.hue    = hue_w_s[DIV_QW-1][HUE_BITS-1:0];
	assign out_word.sat    = sat_w_s[DIV_QW-1][SAT_BITS-1:0];
	assign out_word.bright = bright_s[DIV_QW-1];

endmodule

`default_nettype wire

@@ hdl/rgb_to_hsv_converter.sv @@
// Top level of the RGB to HSV converter: input skid, front stages and divider pipeline.
// Throughput: one word per cycle while hsv.ready does not stall the pipe; the 16-stage
// divider (one quotient bit a stage) sets depth.
// Back pressure: hsv.ready freezes all stages at once; a one-word skid on the input keeps
// rgb.ready a register output, so no combinational path runs from hsv.ready to rgb.ready.
// Reset: arst_n clears all valid bits and the skid; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter import rhc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rhc_rgb_if.sink   rgb,
	rhc_hsv_if.source hsv
);

	// ---------------------------------------------------------------
	// Pipeline advance and input skid
	// ---------------------------------------------------------------
	logic          en;
	logic          skid_v_q;
	rhc_chan_t     skid_r_q;
	rhc_chan_t     skid_g_q;
	rhc_chan_t     skid_b_q;
	logic          src_v;
	rhc_chan_t     src_r;
	rhc_chan_t     src_g;
	rhc_chan_t     src_b;
	logic          div_out_v;
	rhc_hsv_t      div_out;

	// Whole pipe moves unless the output word is held.
	assign en        = !div_out_v || hsv.ready;
	assign rgb.ready = !skid_v_q;

	// Skid word has priority: it arrived first.
	assign src_v = skid_v_q || rgb.valid;
	assign src_r = skid_v_q ? skid_r_q : rgb.red;
	assign src_g = skid_v_q ? skid_g_q : rgb.green;
	assign src_b = skid_v_q ? skid_b_q : rgb.blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (rgb.valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && rgb.valid && !skid_v_q) begin
			skid_r_q <= rgb.red;
			skid_g_q <= rgb.green;
			skid_b_q <= rgb.blue;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: max, min, sector and signed channel difference
	// Ties pick red, then green.
	// ---------------------------------------------------------------
	logic                  v_s1;
	rhc_chan_t             mx_s1;
	rhc_chan_t             spread_s1;
	logic [CHANNEL_BITS:0] diff_s1;
	rhc_sector_t           sector_s1;

	rhc_chan_t             mx_c;
	rhc_chan_t             mn_rg_c;
	rhc_chan_t             mn_c;
	logic [CHANNEL_BITS:0] diff_c;
	rhc_sector_t           sector_c;

	always_comb begin
		if (src_r >= src_g && src_r >= src_b) begin
			sector_c = SEC_RED;
			mx_c     = src_r;
			diff_c   = {1'b0, src_g} - {1'b0, src_b};
		end else if (src_g >= src_b) begin
			sector_c = SEC_GREEN;
			mx_c     = src_g;
			diff_c   = {1'b0, src_b} - {1'b0, src_r};
		end else begin
			sector_c = SEC_BLUE;
			mx_c     = src_b;
			diff_c   = {1'b0, src_r} - {1'b0, src_g};
		end
		mn_rg_c = (src_r <= src_g) ? src_r : src_g;
		mn_c    = (mn_rg_c <= src_b) ? mn_rg_c : src_b;
	end

	// ---------------------------------------------------------------
	// Stage 2: degrees * spread = 60*diff + base*spread, and the
	// saturation numerator spread*65535
	// ---------------------------------------------------------------
	logic                           v_s2;
	rhc_chan_t                      mx_s2;
	rhc_chan_t                      spread_s2;
	logic [DEG_W-1:0]               deg_s2;
	logic [CHANNEL_BITS+SAT_BITS-1:0] sat_num_s2;

	logic [DEG_W-1:0]               diff_x;
	logic [DEG_W-1:0]               spread_x;
	logic [DEG_W-1:0]               base_c;
	logic [DEG_W-1:0]               deg_c;
	logic [CHANNEL_BITS+SAT_BITS-1:0] sat_num_c;

	always_comb begin
		unique case (sector_s1)
			SEC_RED:   base_c = '0;
			SEC_GREEN: base_c = DEG_W'(GREEN_BASE);
			SEC_BLUE:  base_c = DEG_W'(BLUE_BASE);
			default:   base_c = '0;
		endcase
		diff_x    = {{(DEG_W-CHANNEL_BITS-1){diff_s1[CHANNEL_BITS]}}, diff_s1};
		spread_x  = DEG_W'(spread_s1);
		// two's complement products; wrap mod 2^DEG_W keeps the sign right
		deg_c     = diff_x * DEG_W'(SECTOR_DEG) + base_c * spread_x;
		sat_num_c = {spread_s1, {SAT_BITS{1'b0}}} - (CHANNEL_BITS+SAT_BITS)'(spread_s1);
	end

	// ---------------------------------------------------------------
	// Stage 3: wrap a negative hue by 360 degrees, scale by the hue
	// fraction, and pick divisors (zero divisor forced to one: the
	// numerator is then zero, so the quotient is zero)
	// ---------------------------------------------------------------
	logic             v_s3;
	rhc_div_word_t    word_s3;

	logic [DEG_W-1:0] deg_wrap_c;
	rhc_div_word_t    word_c;

	always_comb begin
		if (deg_s2[DEG_W-1]) begin
			deg_wrap_c = deg_s2 + DEG_W'(FULL_DEG) * DEG_W'(spread_s2);
		end else begin
			deg_wrap_c = deg_s2;
		end
		word_c.hue_num = DIV_W'(deg_wrap_c[DEG_POS_W-1:0]) << HUE_FRAC_BITS;
		word_c.hue_den = (spread_s2 == '0) ? CHANNEL_BITS'(1) : spread_s2;
		word_c.sat_num = DIV_W'(sat_num_s2);
		word_c.sat_den = (mx_s2 == '0) ? CHANNEL_BITS'(1) : mx_s2;
		word_c.bright  = mx_s2;
	end

	// ---------------------------------------------------------------
	// Front stage registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1      <= mx_c;
			spread_s1  <= mx_c - mn_c;
			diff_s1    <= diff_c;
			sector_s1  <= sector_c;
			mx_s2      <= mx_s1;
			spread_s2  <= spread_s1;
			deg_s2     <= deg_c;
			sat_num_s2 <= sat_num_c;
			word_s3    <= word_c;
		end
	end

	// ---------------------------------------------------------------
	// Divider pipeline; its last stage is the output register
	// ---------------------------------------------------------------
	rhc_pipe_ctl_t div_ctl;

	assign div_ctl.en    = en;
	assign div_ctl.valid = v_s3;

	rhc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.in_word   (word_s3),
		.out_valid (div_out_v),
		.out_word  (div_out)
	);

	assign hsv.valid      = div_out_v;
	assign hsv.hue        = div_out.hue;
	assign hsv.saturation = div_out.sat;
	assign hsv.brightness = div_out.bright;

endmodule

`default_nettype wire

@@ hdl/rhc_checker.sv @@
// Port-level assertions of the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_converter_macros.svh"

module rhc_checker import rhc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rgb_valid,
	input logic                rgb_ready,
	input logic                hsv_valid,
	input logic                hsv_ready,
	input logic [HUE_BITS-1:0] hsv_hue,
	input logic [SAT_BITS-1:0] hsv_saturation,
	input rhc_chan_t           hsv_brightness
);

	`RHC_ASSERT_NEXT(a_out_hold, clk, arst_n, hsv_valid && !hsv_ready, hsv_valid && $stable(hsv_hue) && $stable(hsv_saturation) && $stable(hsv_brightness), "stalled hsv word changed")
	`RHC_ASSERT_IMP(a_skid_cause, clk, arst_n, $fell(rgb_ready), $past(rgb_valid && hsv_valid && !hsv_ready), "rgb ready dropped without a stalled output")
	`RHC_ASSERT_IMP(a_gray_hue, clk, arst_n, hsv_valid && hsv_saturation == '0, hsv_hue == '0, "unsaturated word has nonzero hue")
	`RHC_ASSERT_IMP(a_hue_range, clk, arst_n, hsv_valid, hsv_hue < HUE_BITS'(FULL_DEG << HUE_FRAC_BITS), "hue at or above 360 degrees")

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rgb_valid      (rgb.valid),
	.rgb_ready      (rgb.ready),
	.hsv_valid      (hsv.valid),
	.hsv_ready      (hsv.ready),
	.hsv_hue        (hsv.hue),
	.hsv_saturation (hsv.saturation),
	.hsv_brightness (hsv.brightness)
);

`default_nettype wire

@@ bench/tb_rgb_to_hsv_converter.sv @@
// Self-checking testbench for the RGB to HSV converter: directed corners, random pixels, stalls.
`timescale 1ns / 1ps
`default_nettype none

module tb_rgb_to_hsv_converter;
	import rhc_pkg::*;

	// longest quiet stretch is the long output hold plus pipeline drain
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 2 * (2 + DIV_QW) + 8;
	localparam int SAT_FULL       = (1 << SAT_BITS) - 1;

	logic clk;
	logic arst_n;

	rhc_rgb_if rgb_bus ();
	rhc_hsv_if hsv_bus ();

	rgb_to_hsv_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rgb    (rgb_bus),
		.hsv    (hsv_bus)
	);

	// expected HSV words, oldest first
	rhc_hsv_t hsv_expect_q[$];
	int       mismatches;
	bit       idling_on;       // random gaps on both sides of the block
	bit       hold_requested;  // set by the stall test, cleared by the receiver

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Integer HSV of one pixel. Hue numerator is (60*diff + base*spread) << frac,
	// wrapped into one full turn, then floored over the spread.
	function automatic rhc_hsv_t convert_pixel(input rhc_chan_t r, input rhc_chan_t g,
			input rhc_chan_t b);
		longint      rr, gg, bb, top, bottom, spread, diff, base_deg, num, turn, one;
		rhc_sector_t sector;
		rhc_hsv_t    px;
		rr = r;
		gg = g;
		bb = b;
		top = rr;
		bottom = rr;
		if (gg > top) top = gg;
		if (bb > top) top = bb;
		if (gg < bottom) bottom = gg;
		if (bb < bottom) bottom = bb;
		spread = top - bottom;
		one = longint'(1) << HUE_FRAC_BITS;
		// ties go to red first, then green
		if (top == rr) sector = SEC_RED;
		else if (top == gg) sector = SEC_GREEN;
		else sector = SEC_BLUE;
		case (sector)
			SEC_RED: begin
				diff = gg - bb;
				base_deg = 0;
			end
			SEC_GREEN: begin
				diff = bb - rr;
				base_deg = GREEN_BASE;
			end
			default: begin
				diff = rr - gg;
				base_deg = BLUE_BASE;
			end
		endcase
		px.hue = '0;
		if (spread != 0) begin
			num = (SECTOR_DEG * diff + base_deg * spread) * one;
			turn = FULL_DEG * one * spread;
			if (num < 0) num += turn;
			if (num >= turn) num -= turn;
			px.hue = HUE_BITS'(num / spread);
		end
		// black pixel: no saturation
		px.sat = (top == 0) ? '0 : SAT_BITS'((spread * SAT_FULL) / top);
		px.bright = rhc_chan_t'(top);
		return px;
	endfunction

	// Offers one pixel from a falling edge and returns at the falling edge after
	// the accepting rising edge. valid stays high between back-to-back words.
	task automatic send_pixel(input rhc_chan_t r, input rhc_chan_t g, input rhc_chan_t b);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			rgb_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		rgb_bus.valid <= 1'b1;
		rgb_bus.red   <= r;
		rgb_bus.green <= g;
		rgb_bus.blue  <= b;
		do @(posedge clk); while (!rgb_bus.ready);
		@(negedge clk);
	endtask

	// channel value close to a base, clipped to the channel range
	function automatic rhc_chan_t near_value(input int base);
		int v;
		v = base + int'($urandom_range(0, 6)) - 3;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return rhc_chan_t'(v);
	endfunction

	// Corners: black, white, grays, primaries, secondaries, every tie pattern,
	// red sector wrapping below zero, and single-step spreads.
	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);    // black
		send_pixel(8'd255, 8'd255, 8'd255);  // white
		send_pixel(8'd128, 8'd128, 8'd128);  // gray
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);    // primaries
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie
		send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie
		send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie, wraps negative
		send_pixel(8'd200, 8'd200, 8'd50);
		send_pixel(8'd50,  8'd200, 8'd200);
		send_pixel(8'd200, 8'd50,  8'd200);
		send_pixel(8'd255, 8'd0,   8'd1);    // red sector just below 360
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd1,   8'd0,   8'd0);    // smallest nonzero spread
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd170, 8'd85,  8'd255);
		send_pixel(8'd7,   8'd3,   8'd11);
	endtask

	// Mix of uniform pixels, near-gray pixels (tiny spreads) and forced ties;
	// gap density changes every hundred words.
	task automatic test_random_pixels(input int count);
		rhc_chan_t r, g, b;
		int        base;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
			r = rhc_chan_t'($urandom);
			g = rhc_chan_t'($urandom);
			b = rhc_chan_t'($urandom);
			case ($urandom_range(0, 3))
				2: begin
					base = $urandom_range(0, 255);
					r = near_value(base);
					g = near_value(base);
					b = near_value(base);
				end
				3: begin
					case ($urandom_range(0, 2))
						0: g = r;
						1: b = g;
						default: b = r;
					endcase
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Output held off for a long stretch while words keep coming: the pipeline
	// and skid fill, rgb.ready drops, then everything drains in order.
	task automatic test_output_hold(input int count);
		idling_on = 1'b0;
		hold_requested = 1'b1;
		for (int i = 0; i < count; i++)
			send_pixel(rhc_chan_t'($urandom), rhc_chan_t'($urandom), rhc_chan_t'($urandom));
	endtask

	// Full rate at the tail, no gaps on either side.
	task automatic test_full_rate(input int count);
		idling_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_pixel(rhc_chan_t'($urandom), rhc_chan_t'($urandom), rhc_chan_t'($urandom));
	endtask

	// Scoreboard: predict on each accepted RGB word, check each accepted HSV word.
	always @(posedge clk) begin
		rhc_hsv_t want;
		if (arst_n && rgb_bus.valid && rgb_bus.ready)
			hsv_expect_q.push_back(convert_pixel(rgb_bus.red, rgb_bus.green, rgb_bus.blue));
		if (arst_n && hsv_bus.valid && hsv_bus.ready) begin
			if (hsv_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected HSV word hue %0d sat %0d bright %0d", $time,
					hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness);
			end else begin
				want = hsv_expect_q.pop_front();
				if (hsv_bus.hue !== want.hue) begin
					mismatches++;
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, hsv_bus.hue);
				end
				if (hsv_bus.saturation !== want.sat) begin
					mismatches++;
					$display("%0t: saturation expected %0d actual %0d", $time, want.sat,
						hsv_bus.saturation);
				end
				if (hsv_bus.brightness !== want.bright) begin
					mismatches++;
					$display("%0t: brightness expected %0d actual %0d", $time, want.bright,
						hsv_bus.brightness);
				end
			end
		end
	end

	// Output side: random stall bursts, or one long hold on request.
	initial begin : hsv_receiver
		hsv_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_requested) begin
				hsv_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_requested = 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				hsv_bus.ready <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else begin
				hsv_bus.ready <= 1'b1;
			end
		end
	end

	// Ends the run if no word moves on either side for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rgb_bus.valid && rgb_bus.ready) || (hsv_bus.valid && hsv_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("rgb_to_hsv_converter verification failed");
		$finish;
	end

	initial begin : test_sequence
		mismatches     = 0;
		idling_on      = 1'b1;
		hold_requested = 1'b0;
		arst_n         = 1'b0;
		rgb_bus.valid  = 1'b0;
		rgb_bus.red    = '0;
		rgb_bus.green  = '0;
		rgb_bus.blue   = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_corner_pixels();
		test_random_pixels(700);
		test_output_hold(80);
		test_full_rate(750);
		rgb_bus.valid <= 1'b0;

		// drain, then wait out DRAIN_CYCLES more to catch stray words
		while (hsv_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("rgb_to_hsv_converter verification clean");
		else
			$display("rgb_to_hsv_converter verification failed");
		$finish;
	end

endmodule

`default_nettype wire
